// File: rtl/bfba_pkg.sv
// ============================================================================
// bfba_pkg
// Shared types, codes and the gap-evaluation function of the buffer allocator.
// ============================================================================
`default_nettype none

package bfba_pkg;

    localparam int DATA_W = 25;
    localparam int ID_W   = 16;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] CLS_L0   = 2'd1;
    localparam logic [1:0] CLS_BIAS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP_ID    = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic              any;
        logic              head;
        logic              tail;
        logic [DATA_W-1:0] best_off;
        logic [DATA_W-1:0] best_len;
    } gap_fit_t;

    // Fold one free gap [gs, ge) into the running best fit.
    function automatic gap_fit_t consider_gap(
        input gap_fit_t          fit,
        input logic [DATA_W-1:0] gs,
        input logic [DATA_W-1:0] ge,
        input logic [DATA_W-1:0] req,
        input logic [DATA_W-1:0] mem
    );
        gap_fit_t          r;
        logic [DATA_W-1:0] len;
        r   = fit;
        len = ge - gs;
        if (len >= req)
        begin
            if (gs == '0)
                r.head = 1'b1;
            if (ge == mem)
                r.tail = 1'b1;
            if (!fit.any || len < fit.best_len)
            begin
                r.any      = 1'b1;
                r.best_off = gs;
                r.best_len = len;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bfba_table.sv
// ============================================================================
// bfba_table
// Range table kept sorted by offset; insert and delete shift entries in place.
// ============================================================================
`default_nettype none

module bfba_table
    import bfba_pkg::*;
#(
    parameter int MAX_SLICES = 32,
    parameter int IDX_W      = 5,
    parameter int CNT_W      = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic [DATA_W-1:0]      rd_off,
    output logic [DATA_W-1:0]      rd_len,
    output logic [ID_W-1:0]        rd_id,
    input  wire logic              ins_en,
    input  wire logic [DATA_W-1:0] ins_off,
    input  wire logic [DATA_W-1:0] ins_len,
    input  wire logic [ID_W-1:0]   ins_id,
    input  wire logic              del_en,
    input  wire logic [IDX_W-1:0]  del_idx,
    output logic [CNT_W-1:0]       count
);

    logic [DATA_W-1:0] off_reg [MAX_SLICES];
    logic [DATA_W-1:0] len_reg [MAX_SLICES];
    logic [ID_W-1:0]   id_reg  [MAX_SLICES];
    logic [CNT_W-1:0]  count_reg;
    logic [MAX_SLICES-1:0] gt;

    assign rd_off = off_reg[rd_idx];
    assign rd_len = len_reg[rd_idx];
    assign rd_id  = id_reg[rd_idx];
    assign count  = count_reg;

    // entries above the insert point, monotone since the table is sorted
    always_comb
    begin
        for (int k = 0; k < MAX_SLICES; k++)
            gt[k] = (CNT_W'(k) < count_reg) && (off_reg[k] > ins_off);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_SLICES; k++)
        begin
            if (ins_en)
            begin
                if (k > 0 && gt[(k > 0) ? k - 1 : 0])
                begin
                    off_reg[k] <= off_reg[(k > 0) ? k - 1 : 0];
                    len_reg[k] <= len_reg[(k > 0) ? k - 1 : 0];
                    id_reg[k]  <= id_reg[(k > 0) ? k - 1 : 0];
                end
                else if (gt[k] || CNT_W'(k) == count_reg)
                begin
                    off_reg[k] <= ins_off;
                    len_reg[k] <= ins_len;
                    id_reg[k]  <= ins_id;
                end
            end
            else if (del_en && k < MAX_SLICES - 1 && IDX_W'(k) >= del_idx)
            begin
                off_reg[k] <= off_reg[(k < MAX_SLICES - 1) ? k + 1 : k];
                len_reg[k] <= len_reg[(k < MAX_SLICES - 1) ? k + 1 : k];
                id_reg[k]  <= id_reg[(k < MAX_SLICES - 1) ? k + 1 : k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ins_en)
            count_reg <= count_reg + CNT_W'(1);
        else if (del_en)
            count_reg <= count_reg - CNT_W'(1);
    end

endmodule

`default_nettype wire

// File: rtl/bfba_gap_unit.sv
// ============================================================================
// bfba_gap_unit
// Shared scan unit: one table entry per step, tracks cursor, fit, match, usage.
// ============================================================================
`default_nettype none

module bfba_gap_unit
    import bfba_pkg::*;
#(
    parameter int IDX_W  = 5,
    parameter int USED_W = 31
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              step,
    input  wire logic [DATA_W-1:0] ent_off,
    input  wire logic [DATA_W-1:0] ent_len,
    input  wire logic [ID_W-1:0]   ent_id,
    input  wire logic [IDX_W-1:0]  ent_idx,
    input  wire logic [ID_W-1:0]   req_id,
    input  wire logic [DATA_W-1:0] req_size,
    input  wire logic [DATA_W-1:0] mem_size,
    output gap_fit_t               fit,
    output logic                   found,
    output logic [IDX_W-1:0]       found_idx,
    output logic [USED_W-1:0]      used
);

    gap_fit_t          fit_reg, fit_next;
    logic [DATA_W:0]   cursor_reg, cursor_next;
    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [USED_W-1:0] used_reg;
    logic [DATA_W:0]   ent_end;
    logic [DATA_W-1:0] ge;

    assign ent_end = {1'b0, ent_off} + {1'b0, ent_len};
    assign ge      = (ent_off < mem_size) ? ent_off : mem_size;

    always_comb
    begin
        fit_next = fit_reg;
        if ({1'b0, ge} > cursor_reg)
            fit_next = consider_gap(fit_reg, cursor_reg[DATA_W-1:0], ge, req_size, mem_size);
        cursor_next = (ent_end > cursor_reg) ? ent_end : cursor_reg;
    end

    // close with the trailing gap up to the end of the buffer
    always_comb
    begin
        fit = fit_reg;
        if ({1'b0, mem_size} > cursor_reg)
            fit = consider_gap(fit_reg, cursor_reg[DATA_W-1:0], mem_size, req_size, mem_size);
    end

    assign found     = found_reg;
    assign found_idx = found_idx_reg;
    assign used      = used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg       <= '0;
            cursor_reg    <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            used_reg      <= '0;
        end
        else if (clear)
        begin
            fit_reg    <= '0;
            cursor_reg <= '0;
            found_reg  <= 1'b0;
            used_reg   <= '0;
        end
        else if (step)
        begin
            fit_reg    <= fit_next;
            cursor_reg <= cursor_next;
            used_reg   <= used_reg + USED_W'(ent_len);
            if (!found_reg && ent_id == req_id)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= ent_idx;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/best_fit_buffer_allocator_top.sv
// ============================================================================
// best_fit_buffer_allocator_top
// Best-fit range allocator over a linear buffer with a sorted range table.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: operation,
//   buffer_id, request_size, memory_class. Output channel (out_valid /
//   out_stall) returns one result word per request: status, alloc_offset,
//   is_present, no_contiguous_fit, no_total_fit.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes mem_size;
//   cfg_ready is always high. Write it only while the block is idle.
//   A request scans the N ranges in the table, where N is 0..MAX_SLICES.
//   The single scan unit visits one table entry per cycle in offset order,
//   then the final step settles the trailing gap and commits. One request
//   is in work at a time; in_stall is high from acceptance until the result
//   is committed, so a new request is taken only after the previous commit.
//   The result sits in an output register; a new request is accepted while
//   it waits, but its own result holds in the final step until the receiver
//   stops stalling.
//   Reset empties the table, sets mem_size to 65536 and drops any result.
// ============================================================================
`default_nettype none

module best_fit_buffer_allocator_top
    import bfba_pkg::*;
#(
    parameter int MAX_SLICES = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [ID_W-1:0]   buffer_id,
    input  wire logic [DATA_W-1:0] request_size,
    input  wire logic [1:0]        memory_class,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             status,
    output logic [DATA_W-1:0]      alloc_offset,
    output logic                   is_present,
    output logic                   no_contiguous_fit,
    output logic                   no_total_fit,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SLICES);
    localparam int CNT_W  = $clog2(MAX_SLICES + 1);
    localparam int USED_W = DATA_W + CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] mem_size_reg;

    // request word held for the whole operation
    logic [1:0]        op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [DATA_W-1:0] req_reg;
    logic [1:0]        cls_reg;

    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [DATA_W-1:0] offset_reg;
    logic              present_reg, nocont_reg, nototal_reg;

    logic              accept, finish, last_entry;
    logic [DATA_W-1:0] rd_off, rd_len;
    logic [ID_W-1:0]   rd_id;
    logic [CNT_W-1:0]  count;
    gap_fit_t          fit;
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic [USED_W-1:0] used;

    logic              ins_en, del_en;
    logic [DATA_W-1:0] place;
    logic [2:0]        res_status;
    logic [DATA_W-1:0] res_offset;
    logic              res_present, res_nocont, res_nototal;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign finish     = (state_reg == S_FINAL) && (!out_valid_reg || !out_stall);
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1) == count);
    assign cfg_ready  = 1'b1;

    bfba_table #(
        .MAX_SLICES (MAX_SLICES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx_reg),
        .rd_off  (rd_off),
        .rd_len  (rd_len),
        .rd_id   (rd_id),
        .ins_en  (ins_en),
        .ins_off (place),
        .ins_len (req_reg),
        .ins_id  (id_reg),
        .del_en  (del_en),
        .del_idx (found_idx),
        .count   (count)
    );

    bfba_gap_unit #(
        .IDX_W  (IDX_W),
        .USED_W (USED_W)
    ) u_gap (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .step      (state_reg == S_SCAN),
        .ent_off   (rd_off),
        .ent_len   (rd_len),
        .ent_id    (rd_id),
        .ent_idx   (idx_reg),
        .req_id    (id_reg),
        .req_size  (req_reg),
        .mem_size  (mem_size_reg),
        .fit       (fit),
        .found     (found),
        .found_idx (found_idx),
        .used      (used)
    );

    // Decide the result from the finished scan; L0 prefers head, then tail.
    always_comb
    begin
        res_status  = ST_OK;
        res_offset  = '0;
        res_present = 1'b0;
        res_nocont  = 1'b0;
        res_nototal = 1'b0;
        ins_en      = 1'b0;
        del_en      = 1'b0;
        place       = fit.best_off;
        if (cls_reg == CLS_L0)
        begin
            if (fit.head)
                place = '0;
            else if (fit.tail)
                place = mem_size_reg - req_reg;
        end
        unique case (op_reg)
            OP_ALLOC:
            begin
                if (!fit.any)
                    res_status = ST_NO_FIT;
                else if (found)
                    res_status = ST_DUP_ID;
                else if (count == CNT_W'(MAX_SLICES))
                    res_status = ST_FULL;
                else
                begin
                    res_offset = place;
                    ins_en     = finish;
                end
            end
            OP_FREE:
            begin
                if (!found)
                    res_status = ST_NOT_FOUND;
                else
                    del_en = finish;
            end
            OP_QUERY:
            begin
                res_present = found;
                res_nocont  = (cls_reg == CLS_BIAS && count != '0) || !fit.any;
                res_nototal = (req_reg != '0) &&
                              ((USED_W + 1)'(used) + (USED_W + 1)'(req_reg) >
                               (USED_W + 1)'(mem_size_reg));
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (count == '0) ? S_FINAL : S_SCAN;
            end
            S_SCAN:
            begin
                if (last_entry)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (finish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mem_size_reg  <= DATA_W'(65536);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                idx_reg <= '0;
            else if (state_reg == S_SCAN)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cfg_valid && cfg_ready)
                mem_size_reg <= cfg_data;
            // drop the word once taken, load the new one at commit
            if (finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            id_reg  <= buffer_id;
            req_reg <= request_size;
            cls_reg <= memory_class;
        end
        if (finish)
        begin
            status_reg  <= res_status;
            offset_reg  <= res_offset;
            present_reg <= res_present;
            nocont_reg  <= res_nocont;
            nototal_reg <= res_nototal;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign alloc_offset      = offset_reg;
    assign is_present        = present_reg;
    assign no_contiguous_fit = nocont_reg;
    assign no_total_fit      = nototal_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(MAX_SLICES))
        else $error("range table count beyond capacity");

    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_FINAL)
        else $error("result raised outside the final step");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted request did not start a scan");

    a_single_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ins_en && del_en))
        else $error("insert and delete in the same cycle");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ============================================================================
// Best-fit buffer allocator testbench
// Drives allocate, free, query and unused-code requests with random bursts,
// mem_size writes and receiver stalls, predicts every result with an in-bench
// range table and compares it field by field against the block's output words.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import bfba_pkg::*;

    localparam int SLOTS      = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int ID_POOL    = 40;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] size;
        logic [1:0]        cls;
    } request_t;

    typedef struct packed {
        logic [2:0]        st;
        logic [DATA_W-1:0] off;
        logic              pres;
        logic              nocont;
        logic              nototal;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] operation;
    logic [ID_W-1:0] buffer_id;
    logic [DATA_W-1:0] request_size;
    logic [1:0] memory_class;
    logic out_valid;
    logic out_stall;
    logic [2:0] status;
    logic [DATA_W-1:0] alloc_offset;
    logic is_present;
    logic no_contiguous_fit;
    logic no_total_fit;
    logic cfg_valid;
    logic cfg_ready;
    logic [DATA_W-1:0] cfg_data;

    best_fit_buffer_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .buffer_id(buffer_id),
        .request_size(request_size), .memory_class(memory_class),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .alloc_offset(alloc_offset), .is_present(is_present),
        .no_contiguous_fit(no_contiguous_fit), .no_total_fit(no_total_fit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state: its own copy of the range table and mem_size.
    logic [DATA_W-1:0] buf_bytes;
    logic              tbl_used [SLOTS];
    logic [ID_W-1:0]   tbl_id   [SLOTS];
    logic [DATA_W-1:0] tbl_start[SLOTS];
    logic [DATA_W-1:0] tbl_len  [SLOTS];

    request_t pending_words[$];
    answer_t  expected_answers[$];
    int       error_count;
    int       idle_cycles;
    bit       cfg_req;
    logic [DATA_W-1:0] cfg_value;
    bit       cfg_done;

    // Free gap search, 26-bit math so range ends past 2^25 stay exact.
    function automatic gap_fit_t find_gaps(input logic [DATA_W-1:0] req);
        gap_fit_t f;
        int order[$];
        logic [DATA_W:0] cursor, s, e, ge, len;
        f = '0;
        cursor = 0;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i])
            begin
                int j;
                j = order.size();
                order = {order, i};
                while (j > 0 && tbl_start[order[j-1]] > tbl_start[i])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
        for (int k = 0; k <= order.size(); k++)
        begin
            if (k < order.size())
            begin
                s = tbl_start[order[k]];
                e = s + tbl_len[order[k]];
                ge = (s < buf_bytes) ? s : buf_bytes;
            end
            else
            begin
                e = 0;
                ge = buf_bytes;
            end
            if (ge > cursor)
            begin
                len = ge - cursor;
                if (len >= req)
                begin
                    if (cursor == 0) f.head = 1'b1;
                    if (ge == buf_bytes) f.tail = 1'b1;
                    if (!f.any || len < f.best_len)
                    begin
                        f.any = 1'b1;
                        f.best_off = cursor[DATA_W-1:0];
                        f.best_len = len[DATA_W-1:0];
                    end
                end
            end
            if (e > cursor) cursor = e;
        end
        return f;
    endfunction

    function automatic int lookup_id(input logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_id[i] == id) return i;
        return -1;
    endfunction

    // Compute the answer for one accepted request and update the table.
    function automatic answer_t allocate_answer(input request_t r);
        answer_t a;
        gap_fit_t f;
        int slot;
        logic [DATA_W+5:0] used;
        bit occupied;
        a = '0;
        if (r.op == OP_ALLOC)
        begin
            f = find_gaps(r.size);
            if (!f.any) a.st = ST_NO_FIT;
            else if (lookup_id(r.id) >= 0) a.st = ST_DUP_ID;
            else
            begin
                slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_used[i]) slot = i;
                if (slot < 0) a.st = ST_FULL;
                else
                begin
                    a.st = ST_OK;
                    a.off = f.best_off;
                    if (r.cls == CLS_L0)
                    begin
                        if (f.head) a.off = '0;
                        else if (f.tail) a.off = buf_bytes - r.size;
                    end
                    tbl_used[slot] = 1'b1;
                    tbl_id[slot] = r.id;
                    tbl_start[slot] = a.off;
                    tbl_len[slot] = r.size;
                end
            end
        end
        else if (r.op == OP_FREE)
        begin
            slot = lookup_id(r.id);
            if (slot < 0) a.st = ST_NOT_FOUND;
            else tbl_used[slot] = 1'b0;
        end
        else if (r.op == OP_QUERY)
        begin
            used = 0;
            occupied = 0;
            for (int i = 0; i < SLOTS; i++)
                if (tbl_used[i])
                begin
                    used += tbl_len[i];
                    occupied = 1;
                end
            a.pres = lookup_id(r.id) >= 0;
            f = find_gaps(r.size);
            a.nocont = (r.cls == CLS_BIAS && occupied) || !f.any;
            a.nototal = ((used >= buf_bytes) ? 0 : (buf_bytes - used)) < r.size;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Clock: 20 ns period.
    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Driver: bursts of random length separated by random gaps.
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            operation <= 0; buffer_id <= 0; request_size <= 0; memory_class <= 0;
            burst_left = 0; gap_left = 0;
        end
        else
        begin
            // Retire the word taken at this edge; hold otherwise.
            if (in_valid && !in_stall)
            begin
                expected_answers = {expected_answers,
                                    allocate_answer(pending_words.pop_front())};
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 0;
                end
                else if (pending_words.size() > 0 && !cfg_req)
                begin
                    in_valid <= 1;
                    operation <= pending_words[0].op;
                    buffer_id <= pending_words[0].id;
                    request_size <= pending_words[0].size;
                    memory_class <= pending_words[0].cls;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                    end
                    else burst_left--;
                end
                else in_valid <= 0;
            end
        end
    end

    // Config writer: one word per request from the stimulus process.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 0;
            cfg_data <= 0;
            cfg_done <= 0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            buf_bytes = cfg_data;
            cfg_valid <= 0;
            cfg_done <= 1;
        end
        else if (cfg_req && !cfg_done && !cfg_valid)
        begin
            cfg_valid <= 1;
            cfg_data <= cfg_value;
        end
        else if (!cfg_req) cfg_done <= 0;
    end

    // Monitor: receiver stalls on its own pattern, checks each taken word.
    int stall_mode;
    answer_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            stall_mode = 0;
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (in_valid && !in_stall) idle_cycles = 0;
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result word", 1, 0);
                else
                begin
                    want = expected_answers.pop_front();
                    if (status !== want.st) report_mismatch("status", status, want.st);
                    if (alloc_offset !== want.off)
                        report_mismatch("alloc_offset", alloc_offset, want.off);
                    if (is_present !== want.pres)
                        report_mismatch("is_present", is_present, want.pres);
                    if (no_contiguous_fit !== want.nocont)
                        report_mismatch("no_contiguous_fit", no_contiguous_fit, want.nocont);
                    if (no_total_fit !== want.nototal)
                        report_mismatch("no_total_fit", no_total_fit, want.nototal);
                end
            end
            // Stall pattern changes phase every so often; mode 0 never stalls.
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic request_t make_request(input logic [1:0] op, input int id,
                                              input logic [DATA_W-1:0] size,
                                              input logic [1:0] cls);
        request_t r;
        r.op = op; r.id = id[ID_W-1:0]; r.size = size; r.cls = cls;
        return r;
    endfunction

    // Append one request to the stimulus queue.
    function automatic void add_word(input request_t r);
        pending_words = {pending_words, r};
    endfunction

    // Random size scaled to the current buffer, mostly small.
    function automatic logic [DATA_W-1:0] pick_size(input logic [DATA_W-1:0] mem);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return DATA_W'($urandom_range(0, (1 << DATA_W) - 1));
        if (sel == 1) return mem;
        if (sel == 2) return '0;
        if (mem == 0) return DATA_W'($urandom_range(0, 8));
        if (sel < 12) return DATA_W'($urandom_range(1, (mem / 40) + 1));
        return DATA_W'($urandom_range(1, (mem / 8) + 1));
    endfunction

    task automatic drain_and_write(input logic [DATA_W-1:0] value);
        while (pending_words.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        cfg_value = value;
        cfg_req = 1;
        while (!cfg_done) @(posedge clk);
        cfg_req = 0;
        @(posedge clk);
    endtask

    logic [DATA_W-1:0] phase_mem[6];
    logic [1:0] op_pick;
    int live_ids[$];
    int pick, pid;

    initial
    begin
        error_count = 0;
        cfg_req = 0;
        cfg_value = 0;
        buf_bytes = 65536;
        for (int i = 0; i < SLOTS; i++) tbl_used[i] = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part at the reset size.
        add_word(make_request(OP_QUERY, 16'hFFFF, 25'h1FFFFFF, 2'd0));
        add_word(make_request(OP_ALLOC, 0, 0, 2'd0));
        add_word(make_request(OP_ALLOC, 0, 16, 2'd0));
        add_word(make_request(OP_ALLOC, 16'hFFFF, 100, CLS_L0));
        add_word(make_request(OP_ALLOC, 7, 200, CLS_L0));
        add_word(make_request(OP_ALLOC, 8, 25'h1FFFFFF, 2'd0));
        add_word(make_request(OP_FREE, 0, 0, 2'd0));
        add_word(make_request(OP_ALLOC, 9, 8, 2'd3));
        add_word(make_request(OP_ALLOC, 10, 4, CLS_L0));
        add_word(make_request(OP_QUERY, 7, 10, CLS_BIAS));
        add_word(make_request(OP_FREE, 1234, 0, 2'd0));
        add_word(make_request(2'd3, 16'hAAAA, 25'h1555555, 2'd3));
        add_word(make_request(OP_QUERY, 16'h5555, 25'h0AAAAAA, 2'd0));
        for (int i = 0; i < SLOTS + 1; i++)
            add_word(make_request(OP_ALLOC, 100 + i, 1, 2'd0));
        for (int i = 0; i < SLOTS + 1; i++)
            add_word(make_request(OP_FREE, 100 + i, 0, 2'd0));

        // Phases: zero size, full range, shrinking below live ranges, small.
        phase_mem[0] = 0;
        phase_mem[1] = 25'h1000000;
        phase_mem[2] = 25'h1FFFFFF;
        phase_mem[3] = 300;
        phase_mem[4] = 4096;
        phase_mem[5] = 65536;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_write(phase_mem[ph]);
            for (int n = 0; n < 125; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5) op_pick = OP_ALLOC;
                else if (pick < 8) op_pick = OP_FREE;
                else if (pick < 9) op_pick = OP_QUERY;
                else op_pick = 2'($urandom_range(0, 3));
                if (live_ids.size() > 0 && $urandom_range(0, 3) != 0 && op_pick != OP_ALLOC)
                    pid = live_ids[$urandom_range(0, live_ids.size() - 1)];
                else if ($urandom_range(0, 15) == 0)
                    pid = $urandom_range(0, 65535);
                else
                    pid = $urandom_range(0, ID_POOL);
                if (op_pick == OP_ALLOC) live_ids = {live_ids, pid};
                add_word(make_request(op_pick, pid, pick_size(phase_mem[ph]),
                                      2'($urandom_range(0, 3))));
            end
            if (ph == 2)
            begin
                // Shrink mem_size while ranges past it stay in the table.
                drain_and_write(25'h0100);
                for (int n = 0; n < 20; n++)
                    add_word(make_request(2'($urandom_range(0, 2)),
                        $urandom_range(0, ID_POOL), DATA_W'($urandom_range(0, 300)),
                        2'($urandom_range(0, 3))));
            end
        end

        while (pending_words.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
